### hw/rtl/dnsrqm_pkg.sv
// Shared types, constants and helpers of the DNS response question matcher.
// Holds the label-walk phase and walker record, and the per-byte walk step.
// No dependencies.
`default_nettype none

package dnsrqm_pkg;

  // Default depth of the query byte store
  localparam int MAX_QUESTION_BYTES_DEF = 512;

  // Byte offsets and limits of a DNS message
  localparam logic [15:0] INDEX_SAT       = 16'hFFFF;  // saturated byte index
  localparam logic [15:0] LAST_HEADER_POS = 16'd11;    // final header byte
  localparam logic [15:0] ID_BYTES        = 16'd2;     // transaction id length
  localparam logic [15:0] FLAGS_POS       = 16'd2;     // byte holding QR
  localparam logic [15:0] NAME_START_POS  = 16'd12;    // first question byte
  localparam logic [16:0] HEADER_BYTES    = 17'd12;    // first label length
  localparam logic [16:0] QTAIL_BYTES     = 17'd5;     // root label + qtype/qclass

  // Byte masks and case folding
  localparam logic [7:0] PTR_MASK    = 8'hC0;
  localparam logic [7:0] QR_MASK     = 8'h80;
  localparam logic [7:0] CASE_OFFSET = 8'd32;
  localparam logic [7:0] UPPER_A     = 8'h41;
  localparam logic [7:0] UPPER_Z     = 8'h5A;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_NAME,
    PH_TAIL,
    PH_BAD,
    PH_GOOD
  } phase_t;

  typedef struct packed {
    phase_t      phase;
    logic [16:0] label_pos;   // offset of the next label-length byte
    logic [16:0] qend;        // exclusive end of the question section
  } walk_t;

  // Lower-case an ASCII letter, pass anything else
  function automatic logic [7:0] fold_case(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b >= UPPER_A && b <= UPPER_Z) begin
      r = b + CASE_OFFSET;
    end
    return r;
  endfunction

  // Advance the label walk with byte b at offset pos
  function automatic walk_t walk_byte(input walk_t w, input logic [15:0] pos,
                                      input logic [7:0] b);
    walk_t r;
    r = w;
    if (w.phase == PH_HEADER) begin
      if (pos >= LAST_HEADER_POS) begin
        r.phase = PH_NAME;
      end
    end else if (w.phase == PH_NAME && {1'b0, pos} == w.label_pos) begin
      if (b == 8'd0) begin
        r.qend  = {1'b0, pos} + QTAIL_BYTES;
        r.phase = PH_TAIL;
      end else if ((b & PTR_MASK) != 8'd0) begin
        r.phase = PH_BAD;
      end else begin
        r.label_pos = {1'b0, pos} + 17'd1 + {9'd0, b};
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/dns_response_question_match.sv
// DNS response question matcher, top level.
// Depends on dnsrqm_pkg for the walk phase, walker record and case folding.
`default_nettype none

// Feed a DNS query one byte per item (kind = 0), then its response (kind = 1),
// each message from offset 0 and closed by last. Query bytes below
// MAX_QUESTION_BYTES are kept in an on-chip byte store; both messages have
// their uncompressed question name walked label by label to find where the
// question section ends. A compression pointer, a message cut short inside
// its header, name or qtype/qclass, or a query question running past the
// store makes that message malformed. On the last response byte one item
// comes out: ok = 1 when the latest query finished well formed, the response
// is well formed, QR is set, the transaction id matches and the question
// sections have the same length and bytes (letters compared without case).
// Query bytes and other response bytes give no item. Bytes beyond offset
// 65534 of a message are ignored. Rate: one item per clock, sustained, in any
// mix of query and response bytes; the intake stalls only while a verdict
// sits in the compare stage and the output still holds an unaccepted one.
// The store read and the byte snapshot are registered when the last response
// byte is taken, and the compare stage feeds the result to the output register.
// No clearing pass after reset.

module dns_response_question_match #(
  parameter int MAX_QUESTION_BYTES = dnsrqm_pkg::MAX_QUESTION_BYTES_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       kind,
  input  wire logic [7:0] data_byte,
  input  wire logic       last,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            ok
);

  localparam int          AW       = (MAX_QUESTION_BYTES > 1) ?
                                     $clog2(MAX_QUESTION_BYTES) : 1;
  localparam logic [16:0] MaxBytes = 17'(MAX_QUESTION_BYTES);

  localparam dnsrqm_pkg::walk_t WalkClear = '{
    phase:     dnsrqm_pkg::PH_HEADER,
    label_pos: dnsrqm_pkg::HEADER_BYTES,
    qend:      17'd0
  };

  // ------------------------------------------------------------------
  // Walker state of both messages
  // ------------------------------------------------------------------
  logic [15:0]       q_index;
  dnsrqm_pkg::walk_t q_walk;
  logic [15:0]       r_index;
  dnsrqm_pkg::walk_t r_walk;
  logic              mismatch_seen;

  // Query byte store, read at the response offset
  logic [7:0] store [MAX_QUESTION_BYTES];
  logic [7:0] rd_data;

  // Compare stage: one response byte with its context
  logic        s1_valid;
  logic        s1_live;
  logic        s1_last;
  logic [7:0]  s1_byte;
  logic [15:0] s1_pos;
  logic [16:0] s1_q_qend;
  logic        s1_q_good;
  logic        s1_r_tail;
  logic [15:0] s1_r_index;
  logic [16:0] s1_r_qend;

  logic in_fire;
  logic s1_emit;
  logic s1_adv;

  // ------------------------------------------------------------------
  // Intake: advance the walkers on the accepted byte
  // ------------------------------------------------------------------
  dnsrqm_pkg::walk_t q_cur, q_step, q_walk_next;
  dnsrqm_pkg::walk_t r_step, r_walk_next;
  logic [15:0]       q_index_inc, q_index_next;
  logic [15:0]       r_index_inc, r_index_next;
  logic              q_live, r_live, q_good;

  assign in_fire = in_valid && in_ready;

  always_comb begin
    // A new query restarts its walk on its first byte
    q_cur = (q_index == 16'd0) ? WalkClear : q_walk;
    q_live = (q_index != dnsrqm_pkg::INDEX_SAT);
    q_step = q_live ? dnsrqm_pkg::walk_byte(q_cur, q_index, data_byte) : q_cur;
    q_index_inc = q_live ? q_index + 16'd1 : q_index;
    q_good = (q_step.phase == dnsrqm_pkg::PH_TAIL) &&
             ({1'b0, q_index_inc} >= q_step.qend) && (q_step.qend <= MaxBytes);
    q_walk_next  = q_step;
    q_index_next = q_index_inc;
    if (last) begin
      q_walk_next.phase     = q_good ? dnsrqm_pkg::PH_GOOD : dnsrqm_pkg::PH_BAD;
      q_walk_next.label_pos = dnsrqm_pkg::HEADER_BYTES;
      q_index_next          = 16'd0;
    end

    r_live = (r_index != dnsrqm_pkg::INDEX_SAT);
    r_step = r_live ? dnsrqm_pkg::walk_byte(r_walk, r_index, data_byte) : r_walk;
    r_index_inc  = r_live ? r_index + 16'd1 : r_index;
    r_walk_next  = last ? WalkClear : r_step;
    r_index_next = last ? 16'd0 : r_index_inc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_index <= 16'd0;
      q_walk  <= WalkClear;
      r_index <= 16'd0;
      r_walk  <= WalkClear;
    end else if (in_fire) begin
      if (!kind) begin
        q_index <= q_index_next;
        q_walk  <= q_walk_next;
      end else begin
        r_index <= r_index_next;
        r_walk  <= r_walk_next;
      end
    end
  end

  // Store query bytes; read the stored byte at the response offset
  always_ff @(posedge clk) begin
    if (in_fire && !kind && q_live && ({1'b0, q_index} < MaxBytes)) begin
      store[q_index[AW-1:0]] <= data_byte;
    end
    if (in_fire && kind && r_live && ({1'b0, r_index} < MaxBytes)) begin
      rd_data <= store[r_index[AW-1:0]];
    end
  end

  // Take a response byte into the compare stage with a snapshot of the
  // query walk and of the response walk after this byte
  always_ff @(posedge clk) begin
    if (in_fire && kind) begin
      s1_live    <= r_live;
      s1_last    <= last;
      s1_byte    <= data_byte;
      s1_pos     <= r_index;
      s1_q_qend  <= q_walk.qend;
      s1_q_good  <= (q_walk.phase == dnsrqm_pkg::PH_GOOD);
      s1_r_tail  <= (r_step.phase == dnsrqm_pkg::PH_TAIL);
      s1_r_index <= r_index_inc;
      s1_r_qend  <= r_step.qend;
    end
  end

  // ------------------------------------------------------------------
  // Compare stage
  // ------------------------------------------------------------------
  logic s1_mm;
  logic mm_total;
  logic s1_ok;

  always_comb begin
    s1_mm = 1'b0;
    if (s1_live) begin
      priority if (s1_pos < dnsrqm_pkg::ID_BYTES) begin
        s1_mm = (rd_data != s1_byte);
      end else if (s1_pos == dnsrqm_pkg::FLAGS_POS) begin
        s1_mm = ((s1_byte & dnsrqm_pkg::QR_MASK) == 8'd0);
      end else if (s1_pos >= dnsrqm_pkg::NAME_START_POS &&
                   {1'b0, s1_pos} < s1_q_qend && {1'b0, s1_pos} < MaxBytes) begin
        s1_mm = (dnsrqm_pkg::fold_case(s1_byte) != dnsrqm_pkg::fold_case(rd_data));
      end else begin
        s1_mm = 1'b0;
      end
    end
    mm_total = mismatch_seen || s1_mm;
    s1_ok = s1_q_good && s1_r_tail && ({1'b0, s1_r_index} >= s1_r_qend) &&
            (s1_r_qend == s1_q_qend) && !mm_total;
  end

  // Hold the compare stage only when its result finds the output full
  assign s1_emit  = s1_valid && s1_last;
  assign s1_adv   = !s1_emit || !out_valid || out_ready;
  assign in_ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      mismatch_seen <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_fire && kind;
      end
      if (s1_valid && s1_adv) begin
        mismatch_seen <= s1_last ? 1'b0 : mm_total;
      end
      if (s1_emit && s1_adv) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_emit && s1_adv) begin
      ok <= s1_ok;
    end
  end

  // ------------------------------------------------------------------
  // Assertions
  // ------------------------------------------------------------------
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> in_ready)
    else $error("input stalled with an empty compare stage");

  a_query_index_clears: assert property (@(posedge clk) disable iff (rst)
    (in_fire && !kind && last) |=> (q_index == 16'd0))
    else $error("query index not cleared after its last byte");

  a_mismatch_clears: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_adv && s1_last) |=> !mismatch_seen)
    else $error("mismatch flag survived the end of a response");

  a_resp_never_good: assert property (@(posedge clk) disable iff (rst)
    r_walk.phase != dnsrqm_pkg::PH_GOOD)
    else $error("response walker entered the finished-query phase");

  a_label_pos_floor: assert property (@(posedge clk) disable iff (rst)
    (q_walk.label_pos >= dnsrqm_pkg::HEADER_BYTES) &&
    (r_walk.label_pos >= dnsrqm_pkg::HEADER_BYTES))
    else $error("label position fell inside the header");

endmodule

`default_nettype wire

### sim/tb.sv
`timescale 1ns / 1ps
// Testbench for dns_response_question_match: streams DNS query and response bytes
// and checks every ok verdict against a cycle-free model of the question matcher.
// Depends on dnsrqm_pkg (phase enum, offsets, masks) and the block's RTL.

module tb;

  localparam int CLK_PERIOD   = 12;
  localparam int STORE_BYTES  = dnsrqm_pkg::MAX_QUESTION_BYTES_DEF;
  localparam int LIMIT_CYCLES = 2_000_000;
  localparam int MAX_LABEL    = 63;
  localparam int MAX_PRINTS   = 40;

  typedef logic [7:0] byte_q_t[$];

  // One label walk, as kept for the query stream and for the response stream
  typedef struct packed {
    logic [15:0]        idx;
    logic [16:0]        label_pos;
    dnsrqm_pkg::phase_t phase;
    logic [16:0]        qend;
  } walk_state_t;

  // Ways to spoil an otherwise matching response
  typedef enum int {
    DMG_ID,
    DMG_QR,
    DMG_NAME,
    DMG_TRUNC,
    DMG_PTR,
    DMG_EXTRA_LABEL
  } damage_t;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  logic       kind      = 1'b0;
  logic [7:0] data_byte = 8'd0;
  logic       last      = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       ok;

  // Idle and stall rates, in percent of cycles, set per test
  int idle_pct  = 0;
  int stall_pct = 0;

  // Model state: the stored query bytes, both walks and the running compare
  logic [7:0]  q_bytes [STORE_BYTES];
  walk_state_t qry_walk;
  walk_state_t rsp_walk;
  logic        rsp_differs;
  logic        ok_expect_q[$];
  logic        want_ok;

  // Messages under construction
  byte_q_t qry_msg;
  byte_q_t rsp_msg;
  int      qend_len;

  int bytes_taken       = 0;
  int verdicts_expected = 0;
  int verdicts_checked  = 0;
  int matches_seen      = 0;
  int mismatches        = 0;

  dns_response_question_match i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .kind      (kind),
    .data_byte (data_byte),
    .last      (last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ok        (ok)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // ------------------------------------------------------------------
  // Matcher model
  // ------------------------------------------------------------------

  function automatic logic [7:0] lower_ascii(input logic [7:0] b);
    return (b >= dnsrqm_pkg::UPPER_A && b <= dnsrqm_pkg::UPPER_Z) ?
           b + dnsrqm_pkg::CASE_OFFSET : b;
  endfunction

  function automatic walk_state_t fresh_walk();
    walk_state_t w;
    w.idx       = 16'd0;
    w.label_pos = dnsrqm_pkg::HEADER_BYTES;
    w.phase     = dnsrqm_pkg::PH_HEADER;
    w.qend      = 17'd0;
    return w;
  endfunction

  // Advance one walk by the byte at offset pos: leave the header after its
  // last byte, then hop from label length to label length until the root.
  function automatic walk_state_t advance_walk(input walk_state_t w,
                                               input logic [15:0] pos,
                                               input logic [7:0] b);
    walk_state_t r;
    r = w;
    if (w.phase == dnsrqm_pkg::PH_HEADER) begin
      if (pos >= dnsrqm_pkg::LAST_HEADER_POS) begin
        r.phase = dnsrqm_pkg::PH_NAME;
      end
    end else if (w.phase == dnsrqm_pkg::PH_NAME && {1'b0, pos} == w.label_pos) begin
      if (b == 8'd0) begin
        r.qend  = {1'b0, pos} + dnsrqm_pkg::QTAIL_BYTES;
        r.phase = dnsrqm_pkg::PH_TAIL;
      end else if ((b & dnsrqm_pkg::PTR_MASK) != 8'd0) begin
        // a compression pointer (or the reserved label types) spoils the walk
        r.phase = dnsrqm_pkg::PH_BAD;
      end else begin
        r.label_pos = {1'b0, pos} + 17'd1 + {9'd0, b};
      end
    end
    return r;
  endfunction

  // The question is complete once the root was seen and qtype/qclass are in
  function automatic logic walk_done(input walk_state_t w);
    return w.phase == dnsrqm_pkg::PH_TAIL && {1'b0, w.idx} >= w.qend;
  endfunction

  task automatic reset_matcher();
    foreach (q_bytes[i]) q_bytes[i] = 8'd0;
    qry_walk    = fresh_walk();
    rsp_walk    = fresh_walk();
    rsp_differs = 1'b0;
  endtask

  // Apply one accepted item to the model; queue a verdict on the last
  // response byte.
  task automatic step_matcher(input logic k, input logic [7:0] b, input logic l);
    logic [15:0] pos;
    logic        good;
    if (k == 1'b0) begin
      if (qry_walk.idx == 16'd0) begin
        qry_walk = fresh_walk();
      end
      // bytes past the saturated index are dropped
      if (qry_walk.idx != dnsrqm_pkg::INDEX_SAT) begin
        pos = qry_walk.idx;
        if (pos < STORE_BYTES) begin
          q_bytes[pos] = b;
        end
        qry_walk     = advance_walk(qry_walk, pos, b);
        qry_walk.idx = qry_walk.idx + 16'd1;
      end
      if (l) begin
        good = walk_done(qry_walk) && qry_walk.qend <= 17'(STORE_BYTES);
        qry_walk.phase     = good ? dnsrqm_pkg::PH_GOOD : dnsrqm_pkg::PH_BAD;
        qry_walk.idx       = 16'd0;
        qry_walk.label_pos = dnsrqm_pkg::HEADER_BYTES;
      end
    end else begin
      if (rsp_walk.idx != dnsrqm_pkg::INDEX_SAT) begin
        pos = rsp_walk.idx;
        if (pos < dnsrqm_pkg::ID_BYTES) begin
          if (b != q_bytes[pos]) begin
            rsp_differs = 1'b1;
          end
        end else if (pos == dnsrqm_pkg::FLAGS_POS) begin
          if ((b & dnsrqm_pkg::QR_MASK) == 8'd0) begin
            rsp_differs = 1'b1;
          end
        end else if (pos >= dnsrqm_pkg::NAME_START_POS && {1'b0, pos} < qry_walk.qend &&
                     pos < STORE_BYTES) begin
          // compare against the store as it stands right now
          if (lower_ascii(b) != lower_ascii(q_bytes[pos])) begin
            rsp_differs = 1'b1;
          end
        end
        rsp_walk     = advance_walk(rsp_walk, pos, b);
        rsp_walk.idx = rsp_walk.idx + 16'd1;
      end
      if (l) begin
        ok_expect_q.push_back(qry_walk.phase == dnsrqm_pkg::PH_GOOD &&
                              walk_done(rsp_walk) &&
                              rsp_walk.qend == qry_walk.qend && !rsp_differs);
        verdicts_expected++;
        rsp_walk    = fresh_walk();
        rsp_differs = 1'b0;
      end
    end
  endtask

  // ------------------------------------------------------------------
  // Monitor and checker: sample both handshakes at the rising edge
  // ------------------------------------------------------------------

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_PRINTS) begin
      $display("%0t ns  mismatch: %s", $time, what);
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        step_matcher(kind, data_byte, last);
        bytes_taken++;
      end
      if (out_valid && out_ready) begin
        if (ok_expect_q.size() == 0) begin
          report_mismatch($sformatf("verdict ok=%0b with none pending", ok));
        end else begin
          want_ok = ok_expect_q.pop_front();
          verdicts_checked++;
          if (want_ok) begin
            matches_seen++;
          end
          if (ok !== want_ok) begin
            report_mismatch($sformatf("verdict %0d: ok=%0b, want %0b",
                                      verdicts_checked, ok, want_ok));
          end
        end
      end
    end
  end

  // Receiver: stall out_ready at the current rate, changing at the falling edge
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // ------------------------------------------------------------------
  // Driver
  // ------------------------------------------------------------------

  // Offer one item at the falling edge, idling first at the current rate, and
  // hold it until accepted. Valid stays high into the next item when no idle
  // cycle is drawn.
  task automatic send_byte(input logic k, input logic [7:0] b, input logic l);
    @(negedge clk);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do begin
        @(negedge clk);
      end while ($urandom_range(99) < idle_pct);
    end
    in_valid  <= 1'b1;
    kind      <= k;
    data_byte <= b;
    last      <= l;
    do begin
      @(posedge clk);
    end while (!in_ready);
  endtask

  task automatic send_msg(input logic k, input byte_q_t m);
    foreach (m[i]) begin
      send_byte(k, m[i], i == m.size() - 1);
    end
  endtask

  // Shuffle a query and a response into one stream, each kept in order
  task automatic send_mixed(input byte_q_t qm, input byte_q_t rm);
    int   qi;
    int   ri;
    logic take_q;
    qi = 0;
    ri = 0;
    while (qi < qm.size() || ri < rm.size()) begin
      take_q = (ri >= rm.size()) || (qi < qm.size() && $urandom_range(1) == 0);
      if (take_q) begin
        send_byte(1'b0, qm[qi], qi == qm.size() - 1);
        qi++;
      end else begin
        send_byte(1'b1, rm[ri], ri == rm.size() - 1);
        ri++;
      end
    end
  endtask

  // ------------------------------------------------------------------
  // Message builders
  // ------------------------------------------------------------------

  // Mostly letters of either case, now and then any byte
  function automatic logic [7:0] name_char();
    if ($urandom_range(9) < 7) begin
      return 8'($urandom_range(25)) +
             (($urandom_range(1) == 1) ? dnsrqm_pkg::UPPER_A
                                       : dnsrqm_pkg::UPPER_A + dnsrqm_pkg::CASE_OFFSET);
    end
    return 8'($urandom);
  endfunction

  function automatic int pick_name_bytes();
    int n;
    n = ($urandom_range(9) == 0) ? $urandom_range(40, 80) : $urandom_range(0, 24);
    // a name cannot take one byte before the root
    return (n == 1) ? 0 : n;
  endfunction

  // Build a query: random header, a name of name_bytes before the root (split
  // into labels, all maximal when long_labels), root, qtype/qclass, then extra
  // trailing bytes.
  task automatic build_query(input int name_bytes, input int extra,
                             input logic long_labels);
    int left;
    int hi;
    int len;
    qry_msg.delete();
    repeat (dnsrqm_pkg::HEADER_BYTES) qry_msg.push_back(8'($urandom));
    left = name_bytes;
    while (left > 0) begin
      hi  = (left - 1 > MAX_LABEL) ? MAX_LABEL : left - 1;
      len = long_labels ? hi : $urandom_range(1, hi);
      // never leave a single byte, which no label can fill
      if (left - 1 - len == 1) begin
        len = (len < MAX_LABEL) ? len + 1 : len - 1;
      end
      qry_msg.push_back(8'(len));
      repeat (len) qry_msg.push_back(name_char());
      left -= len + 1;
    end
    qry_msg.push_back(8'd0);
    repeat (4) qry_msg.push_back(8'($urandom));
    qend_len = int'(dnsrqm_pkg::HEADER_BYTES) + name_bytes +
               int'(dnsrqm_pkg::QTAIL_BYTES);
    repeat (extra) qry_msg.push_back(8'($urandom));
  endtask

  // Answer the current query: same header and question with QR set, letters
  // in random case, then some answer bytes.
  task automatic mirror_response(input int answer);
    rsp_msg = qry_msg[0:qend_len - 1];
    rsp_msg[dnsrqm_pkg::FLAGS_POS] = rsp_msg[dnsrqm_pkg::FLAGS_POS] | dnsrqm_pkg::QR_MASK;
    for (int i = dnsrqm_pkg::NAME_START_POS; i < qend_len; i++) begin
      if (lower_ascii(rsp_msg[i]) >= dnsrqm_pkg::UPPER_A + dnsrqm_pkg::CASE_OFFSET &&
          lower_ascii(rsp_msg[i]) <= dnsrqm_pkg::UPPER_Z + dnsrqm_pkg::CASE_OFFSET &&
          $urandom_range(1) == 1) begin
        rsp_msg[i] = rsp_msg[i] ^ dnsrqm_pkg::CASE_OFFSET;
      end
    end
    repeat (answer) rsp_msg.push_back(8'($urandom));
  endtask

  task automatic damage_response(input damage_t d);
    int pos;
    int root;
    root = qend_len - int'(dnsrqm_pkg::QTAIL_BYTES);
    case (d)
      DMG_ID: begin
        pos          = $urandom_range(dnsrqm_pkg::ID_BYTES - 1);
        rsp_msg[pos] = rsp_msg[pos] ^ 8'($urandom_range(1, 255));
      end
      DMG_QR: begin
        rsp_msg[dnsrqm_pkg::FLAGS_POS] = rsp_msg[dnsrqm_pkg::FLAGS_POS] &
                                         ~dnsrqm_pkg::QR_MASK;
      end
      DMG_NAME: begin
        pos          = $urandom_range(dnsrqm_pkg::NAME_START_POS, qend_len - 1);
        rsp_msg[pos] = rsp_msg[pos] ^ 8'($urandom_range(1, 255));
      end
      DMG_TRUNC: begin
        pos     = $urandom_range(1, qend_len - 1);
        rsp_msg = rsp_msg[0:pos - 1];
      end
      DMG_PTR: begin
        rsp_msg[dnsrqm_pkg::NAME_START_POS] = {2'($urandom_range(1, 3)), 6'($urandom)};
      end
      DMG_EXTRA_LABEL: begin
        // one more label moves the question end
        rsp_msg.insert(root, dnsrqm_pkg::UPPER_A);
        rsp_msg.insert(root, 8'd1);
      end
      default: begin
      end
    endcase
  endtask

  // ------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------

  // A question ending one byte past the store; its query also fills every
  // store entry, so no later response reads an entry that was never written.
  // Answer only the header and the start of the name.
  task automatic test_question_past_store();
    build_query(STORE_BYTES + 1 - int'(dnsrqm_pkg::HEADER_BYTES) -
                int'(dnsrqm_pkg::QTAIL_BYTES), 0, 1'b1);
    send_msg(1'b0, qry_msg);
    mirror_response(0);
    rsp_msg = rsp_msg[0:int'(dnsrqm_pkg::NAME_START_POS) + 1];
    send_msg(1'b1, rsp_msg);
  endtask

  // Root-only name, then a short name answered twice, first with no answer bytes and then with one
  task automatic test_name_shapes();
    build_query(0, 0, 1'b0);
    send_msg(1'b0, qry_msg);
    mirror_response(0);
    send_msg(1'b1, rsp_msg);
    build_query(4, 0, 1'b0);
    send_msg(1'b0, qry_msg);
    mirror_response(0);
    send_msg(1'b1, rsp_msg);
    // answer the same query again: the store and query walk must persist
    mirror_response(1);
    send_msg(1'b1, rsp_msg);
  endtask

  // Each way of spoiling a response against a good query
  task automatic test_response_damage();
    damage_t d;
    d = d.first();
    repeat (d.num()) begin
      build_query($urandom_range(2, 6), 1, 1'b0);
      send_msg(1'b0, qry_msg);
      mirror_response(0);
      damage_response(d);
      send_msg(1'b1, rsp_msg);
      d = d.next();
    end
  endtask

  // Pointer-typed first label, then queries cut off in header, name and tail
  task automatic test_query_malformed();
    int cuts [3];
    build_query(4, 0, 1'b0);
    mirror_response(0);
    qry_msg[dnsrqm_pkg::NAME_START_POS] = {2'($urandom_range(1, 3)), 6'($urandom)};
    send_msg(1'b0, qry_msg);
    send_msg(1'b1, rsp_msg);
    cuts[0] = 6;
    cuts[1] = int'(dnsrqm_pkg::NAME_START_POS) + 2;
    cuts[2] = qend_len - 2;
    foreach (cuts[i]) begin
      build_query(4, 0, 1'b0);
      mirror_response(0);
      qry_msg = qry_msg[0:cuts[i] - 1];
      send_msg(1'b0, qry_msg);
      send_msg(1'b1, rsp_msg);
    end
  endtask

  // A new query arriving while a response streams in
  task automatic test_interleaved();
    repeat (2) begin
      build_query($urandom_range(2, 8), 0, 1'b0);
      mirror_response($urandom_range(0, 4));
      send_mixed(qry_msg, rsp_msg);
    end
  endtask

  // Random traffic: mostly matching pairs with random content, some spoiled,
  // some malformed queries, interleaved streams, repeat answers and noise.
  task automatic test_random_traffic(input int s_pct, input int r_pct);
    int      start_bytes;
    int      start_verdicts;
    int      roll;
    byte_q_t noise;
    idle_pct       = s_pct;
    stall_pct      = r_pct;
    start_bytes    = bytes_taken;
    start_verdicts = verdicts_expected;
    while (bytes_taken - start_bytes < 40 || verdicts_expected - start_verdicts < 2) begin
      roll = $urandom_range(99);
      if (roll < 55) begin
        build_query(pick_name_bytes(), $urandom_range(0, 3), 1'b0);
        send_msg(1'b0, qry_msg);
        mirror_response($urandom_range(0, 16));
        if ($urandom_range(3) == 0) begin
          damage_response(damage_t'($urandom_range(0, int'(DMG_EXTRA_LABEL))));
        end
        send_msg(1'b1, rsp_msg);
      end else if (roll < 65) begin
        build_query(pick_name_bytes(), 0, 1'b0);
        mirror_response($urandom_range(0, 8));
        if ($urandom_range(1) == 0) begin
          qry_msg = qry_msg[0:$urandom_range(1, qend_len - 1)];
        end else begin
          qry_msg[dnsrqm_pkg::NAME_START_POS] = {2'($urandom_range(1, 3)), 6'($urandom)};
        end
        send_msg(1'b0, qry_msg);
        send_msg(1'b1, rsp_msg);
      end else if (roll < 80) begin
        build_query(pick_name_bytes(), $urandom_range(0, 3), 1'b0);
        mirror_response($urandom_range(0, 16));
        send_mixed(qry_msg, rsp_msg);
      end else if (roll < 90) begin
        mirror_response($urandom_range(0, 16));
        send_msg(1'b1, rsp_msg);
      end else begin
        noise.delete();
        repeat ($urandom_range(1, 40)) noise.push_back(8'($urandom));
        send_msg(1'($urandom_range(1)), noise);
      end
    end
  endtask

  // ------------------------------------------------------------------
  // Sequence
  // ------------------------------------------------------------------

  initial begin
    reset_matcher();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed cases at full rate
    test_question_past_store();
    test_name_shapes();
    test_response_damage();
    test_query_malformed();
    test_interleaved();

    // random traffic under each idling pattern
    test_random_traffic(0, 0);
    test_random_traffic(79, 0);
    test_random_traffic(0, 79);
    test_random_traffic(7, 7);

    // drop valid, stop stalling and drain every pending verdict
    @(negedge clk);
    in_valid  <= 1'b0;
    stall_pct = 0;
    while (ok_expect_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);

    $display("Streamed %0d message bytes: directed cases, then random traffic",
             bytes_taken);
    $display("under four idle/stall patterns; %0d verdicts checked, %0d matches, %0d bad.",
             verdicts_checked, matches_seen, mismatches);
    if (mismatches == 0) begin
      $display("[dns_response_question_match] OK");
    end else begin
      $display("[dns_response_question_match] ERROR");
    end
    $finish;
  end

  // Hard stop if the block hangs
  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("Timeout after %0d cycles, %0d verdicts pending", LIMIT_CYCLES,
             ok_expect_q.size());
    $display("[dns_response_question_match] ERROR");
    $finish;
  end

endmodule
